>>> src/pab_pkg.sv
// Package for the paged arena bump allocator: field widths, codes and reset values.
// Used by paged_arena_bump_allocator, pab_port_props, pab_checker and tb; depends on nothing else.
package pab_pkg;

    localparam int MAX_PAGES_DEF   = 64;
    localparam int ALIGN_BYTES_DEF = 32;

    localparam int ACTION_W   = 2;
    localparam int SIZE_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int PAGE_IDX_W = 6;
    localparam int OFS_W      = 16;
    localparam int FAIL_W     = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int PB_W      = 16;
    localparam int SL_W      = 12;
    localparam int START_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_START  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATER_START  = 2'd3;

    localparam logic [PB_W-1:0]    PAGE_BYTES_RST  = 16'd4096;
    localparam logic [SL_W-1:0]    SMALL_LIMIT_RST = 12'd4095;
    localparam logic [START_W-1:0] FIRST_START_RST = 8'd56;
    localparam logic [START_W-1:0] LATER_START_RST = 8'd32;

    localparam logic [ACTION_W-1:0] ACT_ALIGNED   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UNALIGNED = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESET     = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE      = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PAGES  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RESET     = 2'd3;

    localparam logic [FAIL_W-1:0] FAIL_LIMIT = 3'd4;
    localparam logic [FAIL_W-1:0] FAIL_MAX   = 3'd7;

endpackage

>>> src/paged_arena_bump_allocator.sv
// Paged arena bump allocator: top level with page state memories and sequencer.
// Depends on pab_pkg.
//
// Each request takes one transfer in and gives one transfer out (no result for the
// unused action code). The page memories have a single read port, so an allocation
// scans one page at a time from the current page; a page append first raises the
// failure count of each page from the current one up to the last but one, and a
// pool reset rewrites each page in use in turn. The next request is taken while a
// result still waits at the output register.
module paged_arena_bump_allocator
    import pab_pkg::*;
#(
    parameter int MAX_PAGES   = MAX_PAGES_DEF,
    parameter int ALIGN_BYTES = ALIGN_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // alloc_size
    input  logic [ACTION_W-1:0]    s_axis_tuser,   // action
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // page_index, byte_offset, zero pad
    output logic [STATUS_W-1:0]    m_axis_tuser,   // status
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    localparam int PG_W    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W   = $clog2(MAX_PAGES + 1);
    localparam int N_W     = 17;
    localparam int RND_SH  = 17;
    localparam int RECIP_W = 18;
    localparam int PROD_W  = N_W + RECIP_W;
    localparam int AL_W    = 9;
    localparam int P_W     = N_W + AL_W;
    localparam int SUM_W   = 18;
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((32'd1 << RND_SH) / ALIGN_BYTES);
    localparam logic [N_W-1:0]     ALIGN_M1 = N_W'(ALIGN_BYTES - 1);
    localparam logic [N_W-1:0]     ALIGN_V  = N_W'(ALIGN_BYTES);
    localparam logic [CNT_W-1:0]   MAX_CNT  = CNT_W'(MAX_PAGES);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_SCAN_RD  = 11'b00000000010,
        S_RND1     = 11'b00000000100,
        S_RND2     = 11'b00000001000,
        S_FIT      = 11'b00000010000,
        S_FAIL_RD  = 11'b00000100000,
        S_FAIL_WR  = 11'b00001000000,
        S_APPEND   = 11'b00010000000,
        S_CLEAR    = 11'b00100000000,
        S_DONE     = 11'b01000000000,
        S_SPARE    = 11'b10000000000
    } state_t;

    // configuration
    logic [PB_W-1:0]    page_bytes_reg;
    logic [SL_W-1:0]    small_limit_reg;
    logic [START_W-1:0] first_start_reg;
    logic [START_W-1:0] later_start_reg;

    // control state
    state_t           state_reg, state_next;
    logic [PG_W-1:0]  pg_reg, pg_next;
    logic [PG_W-1:0]  cur_reg, cur_next;
    logic [PG_W-1:0]  current_reg, current_next;
    logic [CNT_W-1:0] pages_reg, pages_next;
    logic             newp_reg, newp_next;
    logic             fill0_vld_reg, fill0_vld_next;
    logic             fail0_vld_reg, fail0_vld_next;
    logic             m_valid_reg, m_valid_next;

    // payload
    logic [ACTION_W-1:0]   act_reg, act_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [OFS_W-1:0]      x_reg, x_next;
    logic [N_W-1:0]        q0_reg, q0_next;
    logic [N_W-1:0]        pos_reg, pos_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [PAGE_IDX_W-1:0] res_page_reg, res_page_next;
    logic [OFS_W-1:0]      res_ofs_reg, res_ofs_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [PAGE_IDX_W-1:0] m_page_reg, m_page_next;
    logic [OFS_W-1:0]      m_ofs_reg, m_ofs_next;

    // page memories
    logic [OFS_W-1:0]  fill_mem [MAX_PAGES];
    logic [FAIL_W-1:0] fail_mem [MAX_PAGES];
    logic [OFS_W-1:0]  fill_rd_reg;
    logic [FAIL_W-1:0] fail_rd_reg;
    logic              fill_we, fail_we;
    logic [PG_W-1:0]   fill_waddr, fail_waddr;
    logic [OFS_W-1:0]  fill_wdata;
    logic [FAIL_W-1:0] fail_wdata;

    // datapath
    logic              pg_zero;
    logic [OFS_W-1:0]  fill_eff;
    logic [FAIL_W-1:0] fail_eff;
    logic [OFS_W-1:0]  x_src;
    logic [N_W-1:0]    n1, n2, p_lo, r_v, rounded;
    logic [PROD_W-1:0] prod;
    logic [P_W-1:0]    p_full;
    logic [START_W-1:0] start_v;
    logic [N_W-1:0]    end_v, limit_v;
    logic [SUM_W-1:0]  sum_v;
    logic              out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_bytes_reg  <= PAGE_BYTES_RST;
            small_limit_reg <= SMALL_LIMIT_RST;
            first_start_reg <= FIRST_START_RST;
            later_start_reg <= LATER_START_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAGE_BYTES:  page_bytes_reg  <= cfg_wdata[PB_W-1:0];
                CFG_SMALL_LIMIT: small_limit_reg <= cfg_wdata[SL_W-1:0];
                CFG_FIRST_START: first_start_reg <= cfg_wdata[START_W-1:0];
                CFG_LATER_START: later_start_reg <= cfg_wdata[START_W-1:0];
                default:         page_bytes_reg  <= page_bytes_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (fail_we)
        begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        fill_rd_reg <= fill_mem[pg_reg];
        fail_rd_reg <= fail_mem[pg_reg];
    end

    assign pg_zero  = (pg_reg == '0);
    assign fill_eff = (pg_zero && !fill0_vld_reg) ? OFS_W'(FIRST_START_RST) : fill_rd_reg;
    assign fail_eff = (pg_zero && !fail0_vld_reg) ? '0 : fail_rd_reg;
    assign x_src    = newp_reg ? OFS_W'(later_start_reg) : fill_eff;
    assign n1       = N_W'(x_src) + ALIGN_M1;
    assign prod     = PROD_W'(n1) * PROD_W'(RECIP);
    assign n2       = N_W'(x_reg) + ALIGN_M1;
    assign p_full   = P_W'(q0_reg) * P_W'(ALIGN_V);
    assign p_lo     = p_full[N_W-1:0];
    assign r_v      = n2 - p_lo;
    assign rounded  = (r_v >= ALIGN_V) ? (p_lo + ALIGN_V) : p_lo;
    assign start_v  = pg_zero ? first_start_reg : later_start_reg;
    assign end_v    = N_W'(start_v) + N_W'(page_bytes_reg);
    assign limit_v  = N_W'(later_start_reg) + N_W'(page_bytes_reg);
    assign sum_v    = SUM_W'(pos_reg) + SUM_W'(size_reg);
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next      = state_reg;
        pg_next         = pg_reg;
        cur_next        = cur_reg;
        current_next    = current_reg;
        pages_next      = pages_reg;
        newp_next       = newp_reg;
        fill0_vld_next  = fill0_vld_reg;
        fail0_vld_next  = fail0_vld_reg;
        m_valid_next    = m_valid_reg;
        act_next        = act_reg;
        size_next       = size_reg;
        x_next          = x_reg;
        q0_next         = q0_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_ofs_next    = res_ofs_reg;
        m_status_next   = m_status_reg;
        m_page_next     = m_page_reg;
        m_ofs_next      = m_ofs_reg;
        fill_we         = 1'b0;
        fill_waddr      = pg_reg;
        fill_wdata      = pos_reg[OFS_W-1:0];
        fail_we         = 1'b0;
        fail_waddr      = pg_reg;
        fail_wdata      = '0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next        = s_axis_tuser;
                    size_next       = s_axis_tdata[SIZE_W-1:0];
                    res_status_next = ST_TOO_LARGE;
                    res_page_next   = '0;
                    res_ofs_next    = '0;
                    newp_next       = 1'b0;
                    if (s_axis_tuser == ACT_RESET)
                    begin
                        pg_next    = '0;
                        state_next = S_CLEAR;
                    end
                    else if (s_axis_tuser != ACT_NONE)
                    begin
                        pg_next = current_reg;
                        if (s_axis_tdata[SIZE_W-1:0] > SIZE_W'(small_limit_reg))
                        begin
                            state_next = S_DONE;
                        end
                        else if (CNT_W'(current_reg) < pages_reg)
                        begin
                            state_next = S_SCAN_RD;
                        end
                        else
                        begin
                            newp_next  = 1'b1;
                            state_next = S_RND1;
                        end
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_RND1;
            end
            S_RND1:
            begin
                x_next     = x_src;
                q0_next    = prod[RND_SH+N_W-1:RND_SH];
                state_next = S_RND2;
            end
            S_RND2:
            begin
                pos_next   = (newp_reg || act_reg == ACT_ALIGNED) ? rounded : N_W'(x_reg);
                state_next = S_FIT;
            end
            S_FIT:
            begin
                if (!newp_reg)
                begin
                    if (sum_v <= SUM_W'(end_v))
                    begin
                        fill_we         = 1'b1;
                        fill_wdata      = sum_v[OFS_W-1:0];
                        fill0_vld_next  = fill0_vld_reg || pg_zero;
                        res_status_next = ST_OK;
                        res_page_next   = PAGE_IDX_W'(pg_reg);
                        res_ofs_next    = pos_reg[OFS_W-1:0];
                        state_next      = S_DONE;
                    end
                    else if (CNT_W'(pg_reg) + 1'b1 < pages_reg)
                    begin
                        pg_next    = pg_reg + 1'b1;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        newp_next  = 1'b1;
                        state_next = S_RND1;
                    end
                end
                else if (sum_v > SUM_W'(limit_v))
                begin
                    res_status_next = ST_TOO_LARGE;
                    state_next      = S_DONE;
                end
                else if (pages_reg >= MAX_CNT)
                begin
                    res_status_next = ST_NO_PAGES;
                    state_next      = S_DONE;
                end
                else
                begin
                    pg_next  = current_reg;
                    cur_next = current_reg;
                    if (CNT_W'(current_reg) + 1'b1 < pages_reg)
                    begin
                        state_next = S_FAIL_RD;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_FAIL_RD:
            begin
                state_next = S_FAIL_WR;
            end
            S_FAIL_WR:
            begin
                if (fail_eff > FAIL_LIMIT)
                begin
                    cur_next = pg_reg + 1'b1;
                end
                fail_we        = 1'b1;
                fail_wdata     = (fail_eff < FAIL_MAX) ? fail_eff + 1'b1 : fail_eff;
                fail0_vld_next = fail0_vld_reg || pg_zero;
                if (CNT_W'(pg_reg) + 2'd2 < pages_reg)
                begin
                    pg_next    = pg_reg + 1'b1;
                    state_next = S_FAIL_RD;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                fill_we         = 1'b1;
                fill_waddr      = pages_reg[PG_W-1:0];
                fill_wdata      = sum_v[OFS_W-1:0];
                fail_we         = 1'b1;
                fail_waddr      = pages_reg[PG_W-1:0];
                fail_wdata      = '0;
                pages_next      = pages_reg + 1'b1;
                current_next    = cur_reg;
                res_status_next = ST_OK;
                res_page_next   = PAGE_IDX_W'(pages_reg);
                res_ofs_next    = pos_reg[OFS_W-1:0];
                state_next      = S_DONE;
            end
            S_CLEAR:
            begin
                fill_we        = 1'b1;
                fill_wdata     = OFS_W'(start_v);
                fill0_vld_next = fill0_vld_reg || pg_zero;
                if (CNT_W'(pg_reg) + 1'b1 < pages_reg)
                begin
                    pg_next = pg_reg + 1'b1;
                end
                else
                begin
                    res_status_next = ST_RESET;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_page_next   = res_page_reg;
                    m_ofs_next    = res_ofs_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pg_reg        <= '0;
            cur_reg       <= '0;
            current_reg   <= '0;
            pages_reg     <= CNT_W'(1);
            newp_reg      <= 1'b0;
            fill0_vld_reg <= 1'b0;
            fail0_vld_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pg_reg        <= pg_next;
            cur_reg       <= cur_next;
            current_reg   <= current_next;
            pages_reg     <= pages_next;
            newp_reg      <= newp_next;
            fill0_vld_reg <= fill0_vld_next;
            fail0_vld_reg <= fail0_vld_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        size_reg       <= size_next;
        x_reg          <= x_next;
        q0_reg         <= q0_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_ofs_reg    <= res_ofs_next;
        m_status_reg   <= m_status_next;
        m_page_reg     <= m_page_next;
        m_ofs_reg      <= m_ofs_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - OFS_W - PAGE_IDX_W)'(0), m_ofs_reg, m_page_reg};

endmodule

>>> src/pab_checker.sv
// Port-level checker for the paged arena bump allocator, with its bind statement.
// Depends on pab_pkg and the top level paged_arena_bump_allocator.
module pab_port_props
    import pab_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [ACTION_W-1:0]    s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]    m_axis_tuser
);

    // a failed or reset result carries no page and no offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("non-allocation result carries a page or offset");

    // a request that yields a result keeps the input side busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != ACT_NONE) |=> !s_axis_tready)
        else $error("input taken again straight after a request");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind paged_arena_bump_allocator pab_port_props u_pab_port_props (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> verif/pab_checker.sv
// Checker for the paged arena bump allocator: watches the request, result and
// register write ports, predicts each result and compares it field by field.
// Depends on pab_pkg.
module pab_checker
    import pab_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [ACTION_W-1:0]    s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [STATUS_W-1:0]    m_axis_tuser,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,
    output int                     mismatches,
    output int                     pending,
    output int                     n_placed,
    output int                     n_oversize,
    output int                     n_no_pages,
    output int                     n_rewinds,
    output int                     pages_grown
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [PAGE_IDX_W-1:0] page;
        logic [OFS_W-1:0]      offset;
    } alloc_result_t;

    alloc_result_t expected_allocs[$];

    logic [PB_W-1:0]    page_bytes;
    logic [SL_W-1:0]    small_limit;
    logic [START_W-1:0] first_start;
    logic [START_W-1:0] later_start;

    logic [OFS_W-1:0]   fill_at [MAX_PAGES_DEF];
    logic [FAIL_W-1:0]  fail_runs [MAX_PAGES_DEF];
    int unsigned        cur_page;
    int unsigned        used_pages;

    function automatic int unsigned align_up(input int unsigned x);
        return ((x + ALIGN_BYTES_DEF - 1) / ALIGN_BYTES_DEF) * ALIGN_BYTES_DEF;
    endfunction

    function automatic int unsigned start_of(input int unsigned pg);
        return (pg == 0) ? first_start : later_start;
    endfunction

    task automatic place_request(input logic [ACTION_W-1:0] act,
                                 input logic [SIZE_W-1:0] sz);
        alloc_result_t r;
        int unsigned   pos;
        int unsigned   new_pos;
        int unsigned   next_cur;
        bit            placed;
        r = '0;
        placed = 1'b0;
        if (act == ACT_NONE)
            return;
        if (act == ACT_RESET)
        begin
            for (int unsigned pg = 0; pg < used_pages; pg++)
                fill_at[pg] = OFS_W'(start_of(pg));
            r.status = ST_RESET;
        end
        else if (sz > small_limit)
            r.status = ST_TOO_LARGE;
        else
        begin
            for (int unsigned pg = cur_page; pg < used_pages && !placed; pg++)
            begin
                pos = fill_at[pg];
                if (act == ACT_ALIGNED)
                    pos = align_up(pos);
                // a start already past the page end never fits
                if (pos + sz <= start_of(pg) + page_bytes)
                begin
                    fill_at[pg] = OFS_W'(pos + sz);
                    r.status = ST_OK;
                    r.page   = PAGE_IDX_W'(pg);
                    r.offset = OFS_W'(pos);
                    placed   = 1'b1;
                end
            end
            if (!placed)
            begin
                new_pos = align_up(later_start);
                if (new_pos + sz > later_start + page_bytes)
                    r.status = ST_TOO_LARGE;
                else if (used_pages >= MAX_PAGES_DEF)
                    r.status = ST_NO_PAGES;
                else
                begin
                    next_cur = cur_page;
                    for (int unsigned pg = cur_page; pg + 1 < used_pages; pg++)
                    begin
                        if (fail_runs[pg] > FAIL_LIMIT)
                            next_cur = pg + 1;
                        if (fail_runs[pg] < FAIL_MAX)
                            fail_runs[pg] = fail_runs[pg] + 1'b1;
                    end
                    fill_at[used_pages]   = OFS_W'(new_pos + sz);
                    fail_runs[used_pages] = '0;
                    r.status = ST_OK;
                    r.page   = PAGE_IDX_W'(used_pages);
                    r.offset = OFS_W'(new_pos);
                    used_pages++;
                    cur_page = next_cur;
                end
            end
        end
        expected_allocs.push_back(r);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        alloc_result_t want;
        if (!rst_n)
        begin
            page_bytes  = PAGE_BYTES_RST;
            small_limit = SMALL_LIMIT_RST;
            first_start = FIRST_START_RST;
            later_start = LATER_START_RST;
            for (int pg = 0; pg < MAX_PAGES_DEF; pg++)
            begin
                fill_at[pg]   = '0;
                fail_runs[pg] = '0;
            end
            fill_at[0]  = FIRST_START_RST;
            cur_page    = 0;
            used_pages  = 1;
            pages_grown = 1;
            mismatches  = 0;
            n_placed    = 0;
            n_oversize  = 0;
            n_no_pages  = 0;
            n_rewinds   = 0;
            expected_allocs.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PAGE_BYTES:  page_bytes  = cfg_wdata[PB_W-1:0];
                    CFG_SMALL_LIMIT: small_limit = cfg_wdata[SL_W-1:0];
                    CFG_FIRST_START: first_start = cfg_wdata[START_W-1:0];
                    CFG_LATER_START: later_start = cfg_wdata[START_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                case (m_axis_tuser)
                    ST_OK:        n_placed++;
                    ST_TOO_LARGE: n_oversize++;
                    ST_NO_PAGES:  n_no_pages++;
                    default:      n_rewinds++;
                endcase
                if (expected_allocs.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result with none expected, actual status %0d tdata 0x%06h",
                             $time, m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    want = expected_allocs.pop_front();
                    compare_field("status", want.status, m_axis_tuser);
                    compare_field("page_index", want.page, m_axis_tdata[PAGE_IDX_W-1:0]);
                    compare_field("byte_offset", want.offset,
                                  m_axis_tdata[PAGE_IDX_W +: OFS_W]);
                    compare_field("tdata padding", 0,
                                  m_axis_tdata[OUT_TDATA_W-1:PAGE_IDX_W+OFS_W]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                place_request(s_axis_tuser, s_axis_tdata[SIZE_W-1:0]);
            pending <= expected_allocs.size();
            pages_grown = used_pages;
        end
    end

endmodule

>>> verif/tb.sv
// Testbench top for the paged arena bump allocator: clock, reset, request and
// register stimulus with random stalls on both streams, and the final verdict.
// Depends on pab_pkg, paged_arena_bump_allocator and pab_checker.
module tb
    import pab_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 8;
    localparam int QUIET_CYCLES = 500;
    localparam int CYCLE_LIMIT  = 2_500_000;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // alloc_size
    logic [ACTION_W-1:0]    s_axis_tuser  = ACT_ALIGNED;   // action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // page_index, byte_offset, zero pad
    logic [STATUS_W-1:0]    m_axis_tuser;   // status
    logic                   cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = CFG_PAGE_BYTES;
    logic [CFG_W-1:0]       cfg_wdata     = '0;

    int mismatches;
    int pending;
    int n_placed;
    int n_oversize;
    int n_no_pages;
    int n_rewinds;
    int pages_grown;

    int              cycles   = 0;
    int              stall_pct = 0;
    bit              steady   = 1'b0;
    int              requests = 0;
    int              settings_used = 1;
    logic [PB_W-1:0] cur_pb   = PAGE_BYTES_RST;
    logic [SL_W-1:0] cur_sl   = SMALL_LIMIT_RST;

    paged_arena_bump_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    pab_checker watcher (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // stall the result stream in short bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!steady && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [SIZE_W-1:0] sz);
        if (!steady && $urandom_range(0, 99) < stall_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sz;
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (act != ACT_NONE)
            requests++;
    endtask

    // hold off until every expected transfer has come back
    task automatic drain_results(input int quiet);
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (quiet) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [PB_W-1:0] pb, input logic [SL_W-1:0] sl,
                                  input logic [START_W-1:0] fs, input logic [START_W-1:0] ls);
        drain_results(QUIET_CYCLES);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PAGE_BYTES;
        cfg_wdata <= CFG_W'(pb);
        @(posedge clk);
        cfg_index <= CFG_SMALL_LIMIT;
        cfg_wdata <= CFG_W'(sl);
        @(posedge clk);
        cfg_index <= CFG_FIRST_START;
        cfg_wdata <= CFG_W'(fs);
        @(posedge clk);
        cfg_index <= CFG_LATER_START;
        cfg_wdata <= CFG_W'(ls);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_pb = pb;
        cur_sl = sl;
        settings_used++;
    endtask

    task automatic random_items(input int count);
        int                  done;
        int                  cap;
        int                  pick;
        logic [ACTION_W-1:0] act;
        logic [SIZE_W-1:0]   sz;
        done = 0;
        cap = (cur_pb / 3 < cur_sl) ? int'(cur_pb / 3) : int'(cur_sl);
        while (done < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 46)
                act = ACT_ALIGNED;
            else if (pick < 88)
                act = ACT_UNALIGNED;
            else if (pick < 96)
                act = ACT_RESET;
            else
                act = ACT_NONE;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                sz = SIZE_W'($urandom_range(0, 65535));
            else if (pick < 30)
                sz = SIZE_W'($urandom_range(0, cur_sl));
            else
                sz = SIZE_W'($urandom_range(0, cap));
            send_item(act, sz);
            if (act != ACT_NONE)
                done++;
            if ($urandom_range(0, 199) == 0)
                drain_results(0);
        end
    endtask

    task automatic run_phase(input logic [PB_W-1:0] pb, input logic [SL_W-1:0] sl,
                             input logic [START_W-1:0] fs, input logic [START_W-1:0] ls,
                             input int count);
        apply_settings(pb, sl, fs, ls);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
        random_items(count);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stall_pct = 25;
        send_item(ACT_ALIGNED, 16'd0);
        send_item(ACT_UNALIGNED, 16'd1);
        send_item(ACT_ALIGNED, 16'd1);
        send_item(ACT_UNALIGNED, 16'd4095);
        send_item(ACT_ALIGNED, 16'd4095);
        send_item(ACT_ALIGNED, 16'd4096);
        send_item(ACT_UNALIGNED, 16'hFFFF);
        send_item(ACT_NONE, 16'hFFFF);
        send_item(ACT_NONE, 16'd0);
        send_item(ACT_RESET, 16'hA5A5);
        send_item(ACT_ALIGNED, 16'd31);
        send_item(ACT_UNALIGNED, 16'd2730);
        send_item(ACT_ALIGNED, 16'd1365);

        // shrink the pages so that old fills lie past the end
        apply_settings(16'd64, SMALL_LIMIT_RST, FIRST_START_RST, 8'd33);
        send_item(ACT_ALIGNED, 16'd66);
        send_item(ACT_UNALIGNED, 16'd33);
        send_item(ACT_ALIGNED, 16'd33);
        send_item(ACT_UNALIGNED, 16'd64);
        send_item(ACT_RESET, 16'd0);
        send_item(ACT_ALIGNED, 16'd0);
        send_item(ACT_UNALIGNED, 16'd64);

        run_phase(16'd61440, 12'd4095, 8'd255, 8'd255, 120);
        repeat (4)
            run_phase(PB_W'($urandom_range(64, 4096)), SL_W'($urandom_range(0, 4095)),
                      START_W'($urandom_range(0, 255)), START_W'($urandom_range(0, 255)), 120);
        run_phase(16'd64, 12'd0, 8'd255, 8'd33, 60);
        run_phase(16'd64, 12'd4095, 8'd0, 8'd0, 150);
        run_phase(PAGE_BYTES_RST, SMALL_LIMIT_RST, FIRST_START_RST, LATER_START_RST, 100);
        steady = 1'b1;
        random_items(100);
        drain_results(QUIET_CYCLES);

        $display("Sent %0d requests under %0d register settings in %0d cycles",
                 requests, settings_used, cycles);
        $display("Results: %0d placed, %0d oversize, %0d out of pages, %0d rewinds; %0d pages",
                 n_placed, n_oversize, n_no_pages, n_rewinds, pages_grown);
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
